// ----- sv/car_pkg.sv -----
// Shared constants and types for the cumulative-ack receiver.
// No dependencies; imported by the top level.
package car_pkg;

    // Bitmap geometry: the received map is held as rows of WORD_W marks
    localparam int MESSAGE_SLOTS = 1024;
    localparam int WORD_W        = 32;
    localparam int ROWS          = MESSAGE_SLOTS / WORD_W;
    localparam int ROW_W         = $clog2(ROWS);
    localparam int BIT_W         = $clog2(WORD_W);

    // Field widths
    localparam int SEQ_W   = 10;
    localparam int NEXT_W  = $clog2(MESSAGE_SLOTS) + 1;
    localparam int TOTAL_W = 11;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes (word address within the port)
    localparam logic REG_TOTAL_MESSAGES = 1'b0;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(1024);
    localparam logic [NEXT_W-1:0]  SLOTS_CAP   = NEXT_W'(MESSAGE_SLOTS);

    typedef logic [WORD_W-1:0] t_word;

    // Result of a first-zero search over one bitmap row
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } t_zero_hit;

endpackage

// ----- sv/cumulative_ack_receiver.sv -----
// Cumulative-ack receiver top level: stream in, ack stream out, APB register.
// Depends on car_pkg and car_ram.
//
// Receive side of a sliding-window transfer. Each input beat carries one packet
// sequence number; numbers below the effective total (total_messages, capped at
// 1024) are marked in a received bitmap held in a 32 x 32-bit RAM, and while the
// transfer runs each packet yields one ack beat with the next expected number as
// it stood before the packet. An in-order packet moves the pointer past the run
// of marks already received that follows it. The bitmap read is issued when the
// packet beat is accepted; the row is marked and searched in the mark state, a
// walk state reads each further 32-entry row the pointer walks across, one at a
// time through the RAM's single read port, and an emit state loads the ack into
// the output register, waiting while the output is full. A new packet is accepted
// only after that load. Once every message has arrived, beats are still taken and
// give no ack. The bitmap needs no clearing pass: a per-row valid bit, cleared at
// reset, makes an unwritten row read as zero. Writing total_messages leaves the
// bitmap and the pointer untouched.
module cumulative_ack_receiver
    import car_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Packet stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [15:0]        s_tdata,   // [9:0] sequence_number, [15:10] zero
    // Ack stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [9:0] ack_number, [15:10] zero
    output logic [1:0]         m_tuser,   // [0] all_received, [1] bad_sequence
    // Register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MARK = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [TOTAL_W-1:0] r_total;
    logic [NEXT_W-1:0]  r_next, n_next;
    logic [ROWS-1:0]    r_row_vld;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [BIT_W-1:0]   r_bit;
    logic [SEQ_W-1:0]   r_seq;
    logic               r_bad;
    logic [SEQ_W-1:0]   r_ack;
    logic               r_all;
    logic               r_m_tvalid;
    logic [SEQ_W-1:0]   r_m_ack;
    logic               r_m_all;
    logic               r_m_bad;

    logic [NEXT_W-1:0]  eff_total;
    logic               in_beat;
    logic               cfg_wr;
    logic               done;
    logic [SEQ_W-1:0]   in_seq;
    logic               in_bad;
    logic               out_free;

    logic [ROW_W-1:0]   ram_raddr;
    t_word              ram_rdata;
    t_word              row_data;
    t_word              marked;
    t_word              low_mask;
    t_word              search;
    logic               ram_we;
    logic               advance;
    logic               walking;
    t_zero_hit          hit;
    logic [NEXT_W-1:0]  cand;
    logic [NEXT_W-1:0]  next_base;

    // First zero at or above bit 0 of a row
    function automatic t_zero_hit first_zero(input t_word w);
        t_zero_hit h;
        h.found = 1'b0;
        h.idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                h.found = 1'b1;
                h.idx   = BIT_W'(i);
            end
        end
        return h;
    endfunction

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOTAL_MESSAGES);
    assign prdata = (paddr[2] == REG_TOTAL_MESSAGES) ?
                    {{(PDATA_W-TOTAL_W){1'b0}}, r_total} : '0;

    // Effective total: saturate at the slot count
    assign eff_total = ({1'b0, r_total} > {1'b0, SLOTS_CAP}) ?
                       SLOTS_CAP : NEXT_W'(r_total);

    // Input side
    assign s_tready = (r_state == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign in_seq   = s_tdata[SEQ_W-1:0];
    assign done     = r_next >= eff_total;
    assign in_bad   = {1'b0, in_seq} >= eff_total;
    assign out_free = !r_m_tvalid || m_tready;

    // Bitmap row as read, with unwritten rows seen as zero
    assign row_data = r_row_vld[r_row] ? ram_rdata : '0;
    assign marked   = r_bad ? row_data : (row_data | (t_word'(1) << r_bit));
    assign low_mask = (t_word'(1) << r_bit) - t_word'(1);
    assign advance  = !r_bad && ({1'b0, r_seq} == r_next);
    assign walking  = ((r_state == S_MARK) && advance) || (r_state == S_WALK);
    assign search   = (r_state == S_MARK) ? (marked | low_mask) : row_data;
    assign hit      = first_zero(search);
    assign cand     = NEXT_W'({r_row, hit.idx});
    assign next_base = NEXT_W'({r_row, {BIT_W{1'b0}}}) + NEXT_W'(WORD_W);
    assign ram_we   = (r_state == S_MARK) && !r_bad;

    // Read address: the packet's row on acceptance, else the following row
    assign ram_raddr = (r_state == S_IDLE) ? in_seq[SEQ_W-1:BIT_W] : r_row + ROW_W'(1);

    car_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (marked),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: next state, pointer and row
    always_comb begin
        n_state = r_state;
        n_next  = r_next;
        n_row   = r_row;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat && !done) begin
                    n_state = S_MARK;
                    n_row   = in_seq[SEQ_W-1:BIT_W];
                end
            end
            S_MARK, S_WALK: begin
                if (!walking) begin
                    n_state = S_EMIT;
                end else if (hit.found) begin
                    n_next  = (cand > eff_total) ? eff_total : cand;
                    n_state = S_EMIT;
                end else if (next_base >= eff_total) begin
                    n_next  = eff_total;
                    n_state = S_EMIT;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = S_WALK;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_total    <= TOTAL_RESET;
            r_next     <= '0;
            r_row_vld  <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_next  <= n_next;
            if (cfg_wr) begin
                r_total <= pwdata[TOTAL_W-1:0];
            end
            if (ram_we) begin
                r_row_vld[r_row] <= 1'b1;
            end
            if (r_state == S_EMIT && out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Item payload: hold the packet and its ack while the row work runs
    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        if (in_beat) begin
            r_seq <= in_seq;
            r_bit <= in_seq[BIT_W-1:0];
            r_bad <= in_bad;
            r_ack <= r_next[SEQ_W-1:0];
        end
        if (n_state == S_EMIT && r_state != S_EMIT) begin
            r_all <= n_next >= eff_total;
        end
        if (r_state == S_EMIT && out_free) begin
            r_m_ack <= r_ack;
            r_m_all <= r_all;
            r_m_bad <= r_bad;
        end
    end

    // Output beat
    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {{(16-SEQ_W){1'b0}}, r_m_ack};
    assign m_tuser  = {r_m_bad, r_m_all};

endmodule

// ----- sv/car_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module car_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for cumulative_ack_receiver: packet stream in, ack stream out.
// Depends on car_pkg and the block's RTL; predicts every ack beat on its own.
module tb_top;
    import car_pkg::*;

    // One ack beat as the block reports it
    typedef struct packed {
        logic             bad;
        logic             done;
        logic [SEQ_W-1:0] ack;
    } ack_beat_t;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    localparam logic [PADDR_W-1:0] ADDR_TOTAL = PADDR_W'(4 * int'(REG_TOTAL_MESSAGES));
    localparam logic [PADDR_W-1:0] ADDR_SPARE = PADDR_W'(4 * (int'(REG_TOTAL_MESSAGES) + 1));
    localparam int LIMIT_NS    = 5_000_000;
    localparam int SETTLE      = 40;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 400;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata = '0;    // [9:0] sequence_number, [15:10] zero
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [15:0]        m_tdata;         // [9:0] ack_number, [15:10] zero
    logic [1:0]         m_tuser;         // [0] all_received, [1] bad_sequence
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    cumulative_ack_receiver dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow of the receiver: bitmap, pointer and register
    bit                 rx_map [MESSAGE_SLOTS];
    logic [NEXT_W-1:0]  next_seq  = '0;
    logic [TOTAL_W-1:0] total_reg = TOTAL_RESET;

    logic [SEQ_W-1:0]   packets_pending [$];
    ack_beat_t          acks_due [$];
    logic               in_beat = 1'b0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 hold_left = 0;
    int                 mismatch_cnt = 0;
    int                 items_made = 0;
    int                 gen_base = 0;
    int                 final_total;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    // Work out the ack for one accepted packet and advance the shadow state
    task automatic predict_ack(input logic [SEQ_W-1:0] seq);
        logic [NEXT_W-1:0] eff;
        ack_beat_t         beat;
        eff = (total_reg > SLOTS_CAP) ? SLOTS_CAP : total_reg;
        if (next_seq >= eff) return;
        beat.bad = (NEXT_W'(seq) >= eff);
        if (!beat.bad) rx_map[seq] = 1'b1;
        beat.ack = next_seq[SEQ_W-1:0];
        if (!beat.bad && NEXT_W'(seq) == next_seq) begin
            next_seq++;
            while (next_seq < eff && rx_map[next_seq[SEQ_W-1:0]]) next_seq++;
        end
        beat.done = (next_seq >= eff);
        acks_due.push_back(beat);
    endtask

    // Check ack beats against the oldest prediction, then predict for the packet beat
    always @(posedge i_clk) begin : monitor
        ack_beat_t got;
        ack_beat_t want;
        in_beat = i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tuser[1], m_tuser[0], m_tdata[SEQ_W-1:0]};
            if (acks_due.size() == 0) begin
                flag($sformatf("ack beat %0d with none due", got.ack));
            end else begin
                want = acks_due.pop_front();
                if (got !== want) begin
                    flag($sformatf("ack %0d all %0b bad %0b, expected ack %0d all %0b bad %0b",
                                   got.ack, got.done, got.bad, want.ack, want.done, want.bad));
                end
                if (m_tdata[15:SEQ_W] !== '0) begin
                    flag($sformatf("ack pad bits %0h, expected zero", m_tdata[15:SEQ_W]));
                end
            end
        end
        if (in_beat) predict_ack(s_tdata[SEQ_W-1:0]);
    end

    // Offer packet beats, with random gaps
    always @(negedge i_clk) begin : feeder
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_beat) begin
            if (packets_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                s_tdata  <= 16'(packets_pending.pop_front());
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Accept ack beats; a pending hold-off counts down before random stalls resume
    always @(negedge i_clk) begin : sink
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 74; recv_idle_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_idle_pct = 74; end
            IDLE_BOTH: begin send_idle_pct = 36; recv_idle_pct = 36; end
        endcase
    endtask

    task automatic send(input int seq);
        packets_pending.push_back(SEQ_W'(seq));
        items_made++;
    endtask

    // Wait until every beat is out and every ack is in, then let the block go idle
    task automatic settle();
        @(negedge i_clk);
        while (packets_pending.size() != 0 || (s_tvalid && !in_beat) || acks_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register write followed by a read-back of total_messages
    task automatic set_total(input logic [PADDR_W-1:0] addr, input int value);
        logic [PDATA_W-1:0] seen;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_TOTAL) total_reg = TOTAL_W'(value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TOTAL;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        seen = prdata;
        if (seen !== PDATA_W'(total_reg)) begin
            flag($sformatf("total_messages read %0d, expected %0d", seen, total_reg));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Deliver the next window of sequence numbers shuffled, mixed with repeats,
    // stale numbers and strays from anywhere in the space
    task automatic add_window(input int width);
        int order [$];
        int w;
        int j;
        int tmp;
        int r;
        w = (width > MESSAGE_SLOTS - gen_base) ? MESSAGE_SLOTS - gen_base : width;
        for (int i = 0; i < w; i++) order.push_back(gen_base + i);
        for (int i = w - 1; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[k]) begin
            send(order[k]);
            r = $urandom_range(99, 0);
            if (r < 15) begin
                send(order[$urandom_range(k, 0)]);
            end else if (r < 20 && gen_base > 0) begin
                send($urandom_range(gen_base - 1, 0));
            end else if (r < 25) begin
                send($urandom_range(MESSAGE_SLOTS - 1, 0));
            end
        end
        if (w == 0) send($urandom_range(MESSAGE_SLOTS - 1, 0));
        gen_base += w;
    endtask

    task automatic run_phase(input idle_mode_t mode, input int total, input bit squeeze);
        int start;
        set_total(ADDR_TOTAL, total);
        set_idle(mode);
        start = items_made;
        while (items_made - start < PHASE_ITEMS) begin
            add_window(($urandom_range(7, 0) == 0) ? $urandom_range(96, 33)
                                                   : $urandom_range(16, 1));
        end
        // hold the ack side off while packets keep coming, so the input backs up
        if (squeeze) begin
            @(posedge i_clk);
            hold_left = HOLD_CYCLES;
        end
        settle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset total: top sequence number is marked, ack still at zero
        send(1023);
        settle();

        // Smallest total: strays are bad, packet 0 ends the transfer
        set_total(ADDR_TOTAL, 1);
        send(1);
        send(1023);
        send(0);
        send(0);
        settle();

        // Zero total means nothing to receive; a write to a spare address changes nothing
        set_total(ADDR_TOTAL, 0);
        send(0);
        settle();
        set_total(ADDR_SPARE, 1024);
        send(7);
        settle();

        // Oversized total saturates; duplicate, out-of-order run and stale packet
        set_total(ADDR_TOTAL, 2047);
        send(1);
        send(1);
        send(4);
        send(3);
        send(2);
        send(0);
        settle();
        gen_base = 5;

        run_phase(IDLE_NONE, 1024, 1'b1);
        run_phase(IDLE_SEND, 2047, 1'b0);
        run_phase(IDLE_RECV, 900, 1'b0);
        run_phase(IDLE_BOTH, 1024, 1'b0);

        // Run the transfer to completion; later packets give no ack
        final_total = gen_base + 24;
        set_total(ADDR_TOTAL, final_total);
        set_idle(IDLE_BOTH);
        while (gen_base < final_total + 16 && gen_base < MESSAGE_SLOTS) add_window(16);
        send(0);
        send(1023);
        send($urandom_range(MESSAGE_SLOTS - 1, 0));
        settle();

        if (mismatch_cnt == 0) begin
            $display("cumulative_ack_receiver regression: pass");
        end else begin
            $display("cumulative_ack_receiver regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("cumulative_ack_receiver regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/car_pkg.sv
sv/car_ram.sv
sv/cumulative_ack_receiver.sv
tb/sv/tb_top.sv
